@@ rtl/rdsrx_pkg.sv @@
// Shared types and constants of the datagram session receive unit.
`default_nettype none
package rdsrx_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [15:0] MaxPayload      = 16'd1024;
  localparam logic [15:0] PingIntervalRst = 16'd1000;
  localparam logic [15:0] LostTimeoutRst  = 16'd3000;

  // Configuration register indexes.
  localparam logic CFG_PING_INTERVAL = 1'b0;
  localparam logic CFG_LOST_TIMEOUT  = 1'b1;

  typedef enum logic [2:0] {
    CMD_PACKET    = 3'd0,
    CMD_TICK      = 3'd1,
    CMD_HOST_READ = 3'd2,
    CMD_HOST_FREE = 3'd3,
    CMD_CLOSE     = 3'd4,
    CMD_CONNECT   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PKT,
    OP_TICK,
    OP_READ,
    OP_FREE,
    OP_CLOSE
  } op_e;

  typedef enum logic [1:0] {
    TX_NONE = 2'd0,
    TX_ACK  = 2'd1,
    TX_PING = 2'd2
  } tx_kind_e;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_CONNECTED    = 3'd1,
    EV_LOST         = 3'd2,
    EV_DROP_BUSY    = 3'd3,
    EV_OUT_OF_ORDER = 3'd4,
    EV_IGNORED      = 3'd5
  } event_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] session;
    logic [15:0] seq;
    logic        f_rst;
    logic        f_synack;
    logic        f_ping;
    logic        f_data;
    logic        f_ack;
    logic        has_payload;
    logic [10:0] plen;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

@@ rtl/reliable_datagram_session_rx_unit.sv @@
// Top level of the datagram session receive unit.
// The unit takes one transaction per cycle while the FIFO is not full, and returns exactly
// one result for each. A transaction is decoded by the front end, waits in a QueueDepth-entry
// FIFO, and is executed by the session engine, whose result lands in an output register;
// the earliest result passes through the FIFO storage and then the output register before
// it is presented. Input ready falls only when the FIFO is full, which happens when the
// output side stalls. Configuration writes take effect at the clock edge of the write.
`default_nettype none
module reliable_datagram_session_rx_unit #(
  parameter int unsigned QueueDepth = rdsrx_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [15:0] pkt_session_i,
  input  wire logic [15:0] pkt_seq_i,
  input  wire logic        flag_reset_i,
  input  wire logic        flag_synack_i,
  input  wire logic        flag_ping_i,
  input  wire logic        flag_data_i,
  input  wire logic        flag_ack_i,
  input  wire logic [10:0] payload_len_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       tx_kind_o,
  output logic [15:0]      tx_session_o,
  output logic [15:0]      tx_seq_o,
  output logic             deliver_o,
  output logic [10:0]      deliver_len_o,
  output logic             peer_acked_o,
  output logic [15:0]      acked_seq_o,
  output logic [2:0]       event_res_o,
  output logic             connected_o
);

  rdsrx_pkg::item_t   front_item, q_item;
  rdsrx_pkg::q_stat_t q_stat;
  logic               pop;

  assign in_ready_o = !q_stat.full;

  rdsrx_front u_front (
    .cmd_i         (cmd_i),
    .pkt_session_i (pkt_session_i),
    .pkt_seq_i     (pkt_seq_i),
    .flag_reset_i  (flag_reset_i),
    .flag_synack_i (flag_synack_i),
    .flag_ping_i   (flag_ping_i),
    .flag_data_i   (flag_data_i),
    .flag_ack_i    (flag_ack_i),
    .payload_len_i (payload_len_i),
    .item_o        (front_item)
  );

  rdsrx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  rdsrx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_i        (q_item),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tx_kind_o     (tx_kind_o),
    .tx_session_o  (tx_session_o),
    .tx_seq_o      (tx_seq_o),
    .deliver_o     (deliver_o),
    .deliver_len_o (deliver_len_o),
    .peer_acked_o  (peer_acked_o),
    .acked_seq_o   (acked_seq_o),
    .event_res_o   (event_res_o),
    .connected_o   (connected_o)
  );

`ifndef SYNTHESIS
  // The engine never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Any transmitted header carries an open session id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_kind_o != rdsrx_pkg::TX_NONE |-> tx_session_o != 16'd0)
    else $error("header sent without a session");

  // A delivered payload is always acknowledged in the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && deliver_o |-> tx_kind_o == rdsrx_pkg::TX_ACK)
    else $error("delivery without ack");

  // A connect event leaves the session open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == rdsrx_pkg::EV_CONNECTED |-> connected_o)
    else $error("connect event without session");
`endif

endmodule
`default_nettype wire

@@ rtl/rdsrx_front.sv @@
// Front end: decodes the command and screens oversized packets.
`default_nettype none
module rdsrx_front (
  input  wire logic [2:0]     cmd_i,
  input  wire logic [15:0]    pkt_session_i,
  input  wire logic [15:0]    pkt_seq_i,
  input  wire logic           flag_reset_i,
  input  wire logic           flag_synack_i,
  input  wire logic           flag_ping_i,
  input  wire logic           flag_data_i,
  input  wire logic           flag_ack_i,
  input  wire logic [10:0]    payload_len_i,
  output rdsrx_pkg::item_t    item_o
);

  logic too_long;

  assign too_long = {5'd0, payload_len_i} > rdsrx_pkg::MaxPayload;

  always_comb begin
    item_o.session     = pkt_session_i;
    item_o.seq         = pkt_seq_i;
    item_o.f_rst       = flag_reset_i;
    item_o.f_synack    = flag_synack_i;
    item_o.f_ping      = flag_ping_i;
    item_o.f_data      = flag_data_i;
    item_o.f_ack       = flag_ack_i;
    item_o.has_payload = payload_len_i != 11'd0;
    item_o.plen        = payload_len_i;
    case (cmd_i)
      rdsrx_pkg::CMD_PACKET: begin
        // An oversized packet is dropped without any effect on the session.
        item_o.op = too_long ? rdsrx_pkg::OP_NOP : rdsrx_pkg::OP_PKT;
      end
      rdsrx_pkg::CMD_TICK:      item_o.op = rdsrx_pkg::OP_TICK;
      rdsrx_pkg::CMD_HOST_READ: item_o.op = rdsrx_pkg::OP_READ;
      rdsrx_pkg::CMD_HOST_FREE: item_o.op = rdsrx_pkg::OP_FREE;
      rdsrx_pkg::CMD_CLOSE:     item_o.op = rdsrx_pkg::OP_CLOSE;
      rdsrx_pkg::CMD_CONNECT:   item_o.op = rdsrx_pkg::OP_CLOSE;
      default:                  item_o.op = rdsrx_pkg::OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/rdsrx_queue.sv @@
// Small FIFO that decouples the front end from the session engine.
`default_nettype none
module rdsrx_queue #(
  parameter int unsigned Depth = rdsrx_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire rdsrx_pkg::item_t   item_i,
  input  wire logic               pop_i,
  output rdsrx_pkg::item_t        item_o,
  output rdsrx_pkg::q_stat_t      stat_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  rdsrx_pkg::item_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign stat_o.empty = count_q == '0;
  assign stat_o.full  = count_q == Full;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rdsrx_back.sv @@
// Session engine: holds the session state and registers one result per transaction.
`default_nettype none
module rdsrx_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire rdsrx_pkg::item_t   item_i,
  input  wire rdsrx_pkg::q_stat_t q_stat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              tx_kind_o,
  output logic [15:0]             tx_session_o,
  output logic [15:0]             tx_seq_o,
  output logic                    deliver_o,
  output logic [10:0]             deliver_len_o,
  output logic                    peer_acked_o,
  output logic [15:0]             acked_seq_o,
  output logic [2:0]              event_res_o,
  output logic                    connected_o
);

  logic [15:0] ping_int_q, lost_to_q;
  logic [15:0] sess_q, sess_d, last_q, last_d, rx_cnt_q, rx_cnt_d, ping_cnt_q, ping_cnt_d;
  logic        buf_empty_q, buf_empty_d, buf_taken_q, buf_taken_d;
  logic        out_valid_q, out_valid_d;

  rdsrx_pkg::tx_kind_e tx_kind_d;
  rdsrx_pkg::event_e   event_d;
  logic [15:0] tx_session_d, tx_seq_d, acked_seq_d;
  logic        deliver_d, peer_acked_d;
  logic [10:0] deliver_len_d;

  logic [15:0] seq_diff, rx_inc, ping_inc;

  assign pop_o       = !q_stat_i.empty && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign seq_diff    = item_i.seq - last_q;
  assign rx_inc      = (rx_cnt_q == 16'hFFFF) ? rx_cnt_q : rx_cnt_q + 16'd1;
  assign ping_inc    = (ping_cnt_q == 16'hFFFF) ? ping_cnt_q : ping_cnt_q + 16'd1;

  always_comb begin
    sess_d        = sess_q;
    last_d        = last_q;
    rx_cnt_d      = rx_cnt_q;
    ping_cnt_d    = ping_cnt_q;
    buf_empty_d   = buf_empty_q;
    buf_taken_d   = buf_taken_q;
    tx_kind_d     = rdsrx_pkg::TX_NONE;
    tx_session_d  = '0;
    tx_seq_d      = '0;
    deliver_d     = 1'b0;
    deliver_len_d = '0;
    peer_acked_d  = 1'b0;
    acked_seq_d   = '0;
    event_d       = rdsrx_pkg::EV_NONE;
    case (item_i.op)
      rdsrx_pkg::OP_PKT: begin
        if (item_i.has_payload && !(buf_empty_q && buf_taken_q)) begin
          event_d = rdsrx_pkg::EV_DROP_BUSY;
        end else if (item_i.f_rst) begin
          if (sess_q != '0) begin
            event_d = rdsrx_pkg::EV_LOST;
          end
          sess_d = '0;
        end else if (item_i.f_synack) begin
          sess_d     = item_i.session;
          last_d     = item_i.seq;
          rx_cnt_d   = '0;
          ping_cnt_d = '0;
          if (item_i.session != '0) begin
            event_d = rdsrx_pkg::EV_CONNECTED;
          end
        end else if (sess_q == '0) begin
          event_d = rdsrx_pkg::EV_IGNORED;
        end else if (item_i.session != sess_q) begin
          sess_d  = '0;
          event_d = rdsrx_pkg::EV_LOST;
        end else begin
          if (item_i.f_ping) begin
            rx_cnt_d = '0;
          end
          if (item_i.f_data) begin
            // Only the low byte of the id difference decides ordering.
            if (seq_diff[7:0] == 8'd1) begin
              if (item_i.has_payload) begin
                last_d        = item_i.seq;
                buf_empty_d   = 1'b0;
                buf_taken_d   = 1'b0;
                deliver_d     = 1'b1;
                deliver_len_d = item_i.plen;
              end
            end else begin
              event_d = rdsrx_pkg::EV_OUT_OF_ORDER;
            end
            rx_cnt_d     = '0;
            tx_kind_d    = rdsrx_pkg::TX_ACK;
            tx_session_d = sess_q;
            tx_seq_d     = last_d;
          end
          if (item_i.f_ack) begin
            peer_acked_d = 1'b1;
            acked_seq_d  = item_i.seq;
            rx_cnt_d     = '0;
          end
        end
      end
      rdsrx_pkg::OP_TICK: begin
        if (sess_q != '0) begin
          rx_cnt_d   = rx_inc;
          ping_cnt_d = ping_inc;
          if (ping_inc >= ping_int_q && rx_inc >= ping_int_q) begin
            tx_kind_d    = rdsrx_pkg::TX_PING;
            tx_session_d = sess_q;
            ping_cnt_d   = '0;
          end
          if (rx_inc >= lost_to_q) begin
            sess_d  = '0;
            event_d = rdsrx_pkg::EV_LOST;
          end
        end
      end
      rdsrx_pkg::OP_READ: begin
        if (sess_q != '0 && !buf_empty_q && !buf_taken_q) begin
          buf_empty_d = 1'b1;
          buf_taken_d = 1'b1;
        end
      end
      rdsrx_pkg::OP_FREE: begin
        buf_empty_d = 1'b1;
      end
      rdsrx_pkg::OP_CLOSE: begin
        sess_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_int_q  <= rdsrx_pkg::PingIntervalRst;
      lost_to_q   <= rdsrx_pkg::LostTimeoutRst;
      sess_q      <= '0;
      last_q      <= '0;
      rx_cnt_q    <= '0;
      ping_cnt_q  <= '0;
      buf_empty_q <= 1'b1;
      buf_taken_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == rdsrx_pkg::CFG_PING_INTERVAL) begin
        ping_int_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == rdsrx_pkg::CFG_LOST_TIMEOUT) begin
        lost_to_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        sess_q      <= sess_d;
        last_q      <= last_d;
        rx_cnt_q    <= rx_cnt_d;
        ping_cnt_q  <= ping_cnt_d;
        buf_empty_q <= buf_empty_d;
        buf_taken_q <= buf_taken_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tx_kind_o     <= tx_kind_d;
      tx_session_o  <= tx_session_d;
      tx_seq_o      <= tx_seq_d;
      deliver_o     <= deliver_d;
      deliver_len_o <= deliver_len_d;
      peer_acked_o  <= peer_acked_d;
      acked_seq_o   <= acked_seq_d;
      event_res_o   <= event_d;
      connected_o   <= sess_d != '0;
    end
  end

endmodule
`default_nettype wire

@@ sim/tb_reliable_datagram_session_rx_unit.sv @@
// Testbench for the datagram session receive unit: random handshakes, a built-in session predictor.
module tb_reliable_datagram_session_rx_unit;
  import rdsrx_pkg::*;

  localparam logic [4:0] F_RST  = 5'b10000;
  localparam logic [4:0] F_SYN  = 5'b01000;
  localparam logic [4:0] F_PING = 5'b00100;
  localparam logic [4:0] F_DATA = 5'b00010;
  localparam logic [4:0] F_ACK  = 5'b00001;
  localparam logic [4:0] F_NONE = 5'b00000;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] sess;
    logic [15:0] seq;
    logic [4:0]  flags;
    logic [10:0] plen;
  } hdr_t;

  typedef struct {
    tx_kind_e    kind;
    logic [15:0] tx_sess;
    logic [15:0] tx_seq;
    logic        deliver;
    logic [10:0] dlen;
    logic        acked;
    logic [15:0] aseq;
    event_e      ev;
    logic        conn;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  cmd_i = '0;
  logic [15:0] pkt_session_i = '0;
  logic [15:0] pkt_seq_i = '0;
  logic        flag_reset_i = 1'b0;
  logic        flag_synack_i = 1'b0;
  logic        flag_ping_i = 1'b0;
  logic        flag_data_i = 1'b0;
  logic        flag_ack_i = 1'b0;
  logic [10:0] payload_len_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  tx_kind_o;
  logic [15:0] tx_session_o;
  logic [15:0] tx_seq_o;
  logic        deliver_o;
  logic [10:0] deliver_len_o;
  logic        peer_acked_o;
  logic [15:0] acked_seq_o;
  logic [2:0]  event_res_o;
  logic        connected_o;

  reliable_datagram_session_rx_unit DUT (.*);

  always #6 clk_i = ~clk_i;

  // Session state as the predictor sees it.
  logic [15:0] s_sess = '0;
  logic [15:0] s_last = '0;
  logic        s_empty = 1'b1;
  logic        s_taken = 1'b1;
  logic [15:0] s_rx_age = '0;
  logic [15:0] s_ping_age = '0;
  logic [15:0] r_ping = PingIntervalRst;
  logic [15:0] r_lost = LostTimeoutRst;

  hdr_t     rx_backlog[$];
  verdict_t owed_results[$];
  hdr_t     on_wire;
  int       send_gap = 0;
  int       stall_left = 0;
  bit       in_fired = 1'b0;
  bit       out_fired = 1'b0;
  bit       no_idle = 1'b0;
  int       errors = 0;
  logic [15:0] cur_sess = '0;
  logic [15:0] cur_seq = '0;

  function automatic verdict_t session_update(hdr_t h);
    verdict_t v;
    logic [15:0] dseq;
    v.kind = TX_NONE;
    v.tx_sess = '0;
    v.tx_seq = '0;
    v.deliver = 1'b0;
    v.dlen = '0;
    v.acked = 1'b0;
    v.aseq = '0;
    v.ev = EV_NONE;
    case (h.cmd)
      CMD_PACKET: begin
        if (h.plen > MaxPayload) begin
          // Oversized payloads vanish without a trace.
        end else if (h.plen != 0 && !(s_empty && s_taken)) begin
          v.ev = EV_DROP_BUSY;
        end else if (h.flags[4]) begin
          if (s_sess != 0) v.ev = EV_LOST;
          s_sess = '0;
        end else if (h.flags[3]) begin
          s_sess = h.sess;
          s_last = h.seq;
          s_rx_age = '0;
          s_ping_age = '0;
          v.ev = (h.sess != 0) ? EV_CONNECTED : EV_NONE;
        end else if (s_sess == 0) begin
          v.ev = EV_IGNORED;
        end else if (h.sess != s_sess) begin
          s_sess = '0;
          v.ev = EV_LOST;
        end else begin
          if (h.flags[2]) s_rx_age = '0;
          if (h.flags[1]) begin
            dseq = h.seq - s_last;
            if (dseq[7:0] == 8'd1) begin
              if (h.plen != 0) begin
                s_last = h.seq;
                s_empty = 1'b0;
                s_taken = 1'b0;
                v.deliver = 1'b1;
                v.dlen = h.plen;
              end
            end else begin
              v.ev = EV_OUT_OF_ORDER;
            end
            s_rx_age = '0;
            v.kind = TX_ACK;
            v.tx_sess = s_sess;
            v.tx_seq = s_last;
          end
          if (h.flags[0]) begin
            v.acked = 1'b1;
            v.aseq = h.seq;
            s_rx_age = '0;
          end
        end
      end
      CMD_TICK: begin
        if (s_sess != 0) begin
          if (s_rx_age != 16'hFFFF) s_rx_age++;
          if (s_ping_age != 16'hFFFF) s_ping_age++;
          if (s_ping_age >= r_ping && s_rx_age >= r_ping) begin
            v.kind = TX_PING;
            v.tx_sess = s_sess;
            s_ping_age = '0;
          end
          if (s_rx_age >= r_lost) begin
            s_sess = '0;
            v.ev = EV_LOST;
          end
        end
      end
      CMD_HOST_READ: begin
        if (s_sess != 0 && !s_empty && !s_taken) begin
          s_empty = 1'b1;
          s_taken = 1'b1;
        end
      end
      CMD_HOST_FREE: s_empty = 1'b1;
      CMD_CLOSE, CMD_CONNECT: s_sess = '0;
      default: ;
    endcase
    v.conn = (s_sess != 0);
    return v;
  endfunction

  function automatic int draw_pause();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function automatic hdr_t mk(logic [2:0] c, logic [15:0] s, logic [15:0] q,
                              logic [4:0] f, logic [10:0] n);
    hdr_t h;
    h.cmd = c;
    h.sess = s;
    h.seq = q;
    h.flags = f;
    h.plen = n;
    return h;
  endfunction

  // Sender: holds each transaction until accepted, then pauses as drawn.
  always @(negedge clk_i) begin : drive_in
    hdr_t h;
    logic v_next;
    v_next = in_valid_i;
    if (!rst_ni) begin
      v_next = 1'b0;
    end else if (in_valid_i && !in_fired) begin
      v_next = 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      v_next = 1'b0;
    end else if (rx_backlog.size() > 0) begin
      h = rx_backlog.pop_front();
      on_wire = h;
      cmd_i <= h.cmd;
      pkt_session_i <= h.sess;
      pkt_seq_i <= h.seq;
      {flag_reset_i, flag_synack_i, flag_ping_i, flag_data_i, flag_ack_i} <= h.flags;
      payload_len_i <= h.plen;
      v_next = 1'b1;
      send_gap = draw_pause();
    end else begin
      v_next = 1'b0;
    end
    in_valid_i <= v_next;
  end

  // Receiver: stalls for a freshly drawn number of cycles after each result.
  always @(negedge clk_i) begin : drive_out
    if (out_fired) stall_left = draw_pause();
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watch
    verdict_t want;
    in_fired = 1'b0;
    out_fired = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        out_fired = 1'b1;
        if (owed_results.size() == 0) begin
          errors++;
          $error("result transaction arrived with nothing outstanding");
        end else begin
          want = owed_results.pop_front();
          check_field("tx_kind", want.kind, tx_kind_o);
          check_field("tx_session", want.tx_sess, tx_session_o);
          check_field("tx_seq", want.tx_seq, tx_seq_o);
          check_field("deliver", want.deliver, deliver_o);
          check_field("deliver_len", want.dlen, deliver_len_o);
          check_field("peer_acked", want.acked, peer_acked_o);
          check_field("acked_seq", want.aseq, acked_seq_o);
          check_field("event_res", want.ev, event_res_o);
          check_field("connected", want.conn, connected_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_fired = 1'b1;
        owed_results.push_back(session_update(on_wire));
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (rx_backlog.size() != 0 || in_valid_i || owed_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PING_INTERVAL) r_ping = val;
    else r_lost = val;
  endtask

  function automatic logic [10:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 11'd0;
    if (r == 3) return 11'd1024;
    if (r < 14) return 11'($urandom_range(1, 64));
    return 11'($urandom_range(1, 1024));
  endfunction

  // Mostly a well-formed session: synack, in-order data, reads and ticks,
  // with a share of stray and foreign headers mixed in.
  task automatic queue_random(input int count, input int burst_max);
    int added;
    int r;
    int n;
    logic [15:0] q;
    logic [10:0] len;
    added = 0;
    while (added < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        cur_sess = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        cur_seq = 16'($urandom);
        len = ($urandom_range(0, 7) == 0) ? pick_len() : 11'd0;
        rx_backlog.push_back(mk(CMD_PACKET, cur_sess, cur_seq,
                                F_SYN | (5'($urandom) & (F_PING | F_DATA | F_ACK)), len));
        added++;
      end else if (r < 45) begin
        q = ($urandom_range(0, 7) == 0) ? 16'($urandom) : cur_seq + 16'd1;
        len = pick_len();
        rx_backlog.push_back(mk(CMD_PACKET, cur_sess, q,
                                F_DATA | (5'($urandom) & (F_PING | F_ACK)), len));
        if (q == cur_seq + 16'd1 && len != 0) cur_seq = q;
        added++;
      end else if (r < 62) begin
        rx_backlog.push_back(mk(CMD_HOST_READ, 16'($urandom), 16'($urandom),
                                5'($urandom), 11'($urandom_range(0, 1024))));
        added++;
      end else if (r < 75) begin
        n = $urandom_range(1, burst_max);
        repeat (n) rx_backlog.push_back(mk(CMD_TICK, 16'($urandom), 16'($urandom),
                                           5'($urandom), 11'($urandom_range(0, 1024))));
        added += n;
      end else if (r < 82) begin
        len = ($urandom_range(0, 3) == 0) ? pick_len() : 11'd0;
        rx_backlog.push_back(mk(CMD_PACKET, cur_sess, 16'($urandom),
                                5'($urandom) & (F_PING | F_ACK), len));
        added++;
      end else if (r < 90) begin
        rx_backlog.push_back(mk(3'($urandom_range(0, 5)), 16'($urandom), 16'($urandom),
                                5'($urandom), 11'($urandom_range(0, 1024))));
        added++;
      end else if (r < 94) begin
        rx_backlog.push_back(mk($urandom_range(0, 1) ? CMD_CLOSE : CMD_CONNECT,
                                16'($urandom), 16'($urandom), 5'($urandom), 11'd0));
        added++;
      end else if (r < 97) begin
        rx_backlog.push_back(mk(CMD_PACKET, 16'($urandom), 16'($urandom),
                                F_RST | 5'($urandom), 11'd0));
        added++;
      end else begin
        rx_backlog.push_back(mk(CMD_PACKET, 16'($urandom), cur_seq + 16'd1,
                                5'($urandom) & (F_PING | F_DATA | F_ACK), 11'd0));
        added++;
      end
    end
  endtask

  initial begin : sequencer
    logic [15:0] ping_tab[7];
    logic [15:0] lost_tab[7];
    int count_tab[7];
    int burst_tab[7];
    ping_tab = '{16'd1000, 16'd1, 16'd4, 16'd65535, 16'd0, 16'd0, 16'd10};
    lost_tab = '{16'd3000, 16'd1, 16'd12, 16'd65535, 16'd20, 16'd0, 16'd30};
    count_tab = '{150, 250, 350, 200, 200, 400, 350};
    burst_tab = '{4, 3, 16, 4, 25, 40, 35};
    // Phase five gets a random moderate setting.
    ping_tab[5] = 16'($urandom_range(2, 30));
    lost_tab[5] = ping_tab[5] + 16'($urandom_range(0, 50));

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed opening at reset register values.
    rx_backlog.push_back(mk(CMD_PACKET, 16'd5, 16'd1, F_DATA, 11'd0));
    rx_backlog.push_back(mk(CMD_TICK, 16'd0, 16'd0, F_NONE, 11'd0));
    rx_backlog.push_back(mk(CMD_HOST_FREE, 16'd0, 16'd0, F_NONE, 11'd0));
    rx_backlog.push_back(mk(CMD_HOST_READ, 16'd0, 16'd0, F_NONE, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0042, 16'd0, F_SYN, 11'd1025));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0043, 16'd0, F_DATA, 11'd2047));
    rx_backlog.push_back(mk(CMD_PACKET, 16'd0, 16'd7, F_SYN, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'hFFFF, 16'hFFFF, F_SYN, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'hFFFF, 16'h0000, F_DATA | F_ACK, 11'd1024));
    rx_backlog.push_back(mk(CMD_PACKET, 16'hFFFF, 16'h0001, F_DATA, 11'd1));
    rx_backlog.push_back(mk(CMD_PACKET, 16'hFFFF, 16'h0000, F_PING, 11'd0));
    rx_backlog.push_back(mk(CMD_HOST_READ, 16'd0, 16'd0, F_NONE, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'hFFFF, 16'h0001, F_DATA, 11'd0));
    // The id difference wraps in its low byte only.
    rx_backlog.push_back(mk(CMD_PACKET, 16'hFFFF, 16'h0101, F_DATA | F_ACK, 11'd7));
    rx_backlog.push_back(mk(CMD_PACKET, 16'hFFFF, 16'h0101, F_DATA, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'hFFFF, 16'h1234, F_ACK | F_PING, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h1234, 16'h0102, F_DATA, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0000, 16'h0000, F_RST, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0001, 16'h8000, F_SYN | F_DATA, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0001, 16'h8001, F_RST | F_SYN, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0002, 16'h0000, F_SYN, 11'd0));
    rx_backlog.push_back(mk(CMD_CLOSE, 16'd0, 16'd0, F_NONE, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0003, 16'h00FF, F_SYN, 11'd0));
    rx_backlog.push_back(mk(CMD_HOST_READ, 16'd0, 16'd0, F_NONE, 11'd0));
    rx_backlog.push_back(mk(CMD_CONNECT, 16'd0, 16'd0, F_NONE, 11'd0));

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      if (p != 0) begin
        set_reg(CFG_PING_INTERVAL, ping_tab[p]);
        set_reg(CFG_LOST_TIMEOUT, lost_tab[p]);
      end
      no_idle = (p == 2 || p == 5);
      queue_random(count_tab[p], burst_tab[p]);
    end

    // Freeing a buffer that was never read leaves it busy for good, so it comes last.
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0777, 16'h0010, F_SYN, 11'd0));
    rx_backlog.push_back(mk(CMD_HOST_READ, 16'd0, 16'd0, F_NONE, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0777, 16'h0011, F_DATA, 11'd9));
    rx_backlog.push_back(mk(CMD_HOST_FREE, 16'd0, 16'd0, F_NONE, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0777, 16'h0012, F_DATA, 11'd4));
    rx_backlog.push_back(mk(CMD_HOST_READ, 16'd0, 16'd0, F_NONE, 11'd0));
    rx_backlog.push_back(mk(CMD_PACKET, 16'h0777, 16'h0012, F_DATA, 11'd0));

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
